>>> rtl/next_prime_finder_defines.svh
// Assertion macros shared by the next prime finder RTL.
`ifndef NEXT_PRIME_FINDER_DEFINES_SVH
`define NEXT_PRIME_FINDER_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define NPF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define NPF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/npf_pkg.sv
// Package with types and constants of the next prime finder.
package npf_pkg;

   localparam int IN_WIDTH           = 32;
   localparam int DEFAULT_DATA_WIDTH = 32;
   localparam int RES_WIDTH          = 31;
   localparam int DIV_WIDTH          = 16;
   localparam int SQ_WIDTH           = 32;
   localparam int DIV_CNT_WIDTH      = $clog2(RES_WIDTH);

   localparam logic [RES_WIDTH-1:0] SMALLEST_PRIME = RES_WIDTH'(2);
   localparam logic [RES_WIDTH-1:0] RESULT_MAX     = {RES_WIDTH{1'b1}};
   localparam logic [DIV_WIDTH-1:0] FIRST_DIVISOR  = DIV_WIDTH'(2);
   localparam logic [SQ_WIDTH-1:0]  FIRST_SQUARE   = SQ_WIDTH'(4);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CAND,
      ST_TEST,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic done;
      logic rem_zero;
   } div_status_type;

endpackage

>>> rtl/npf_divider.sv
// Bit-serial restoring remainder unit: one dividend bit per cycle.
module npf_divider
   import npf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [RES_WIDTH-1:0] dividend,
   input  logic [DIV_WIDTH-1:0] divisor,
   output logic                 busy,
   output div_status_type       status
);

   logic [RES_WIDTH-1:0]     dvd_ff, dvd_in;
   logic [DIV_WIDTH-1:0]     dsr_ff, dsr_in;
   logic [DIV_WIDTH-1:0]     rem_ff, rem_in;
   logic [DIV_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [DIV_WIDTH:0]       shifted;
   logic [DIV_WIDTH:0]       diff;

   assign shifted = {rem_ff, dvd_ff[RES_WIDTH-1]};
   assign diff    = shifted - {1'b0, dsr_ff};

   always_comb begin
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
         cnt_in  = DIV_CNT_WIDTH'(RES_WIDTH - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[RES_WIDTH-2:0], 1'b0};
         // Restore when the partial remainder is below the divisor.
         rem_in = diff[DIV_WIDTH] ? shifted[DIV_WIDTH-1:0] : diff[DIV_WIDTH-1:0];
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy            = busy_ff;
   assign status.done     = done_ff;
   assign status.rem_zero = (rem_ff == '0);

endmodule

>>> rtl/next_prime_finder.sv
// Top level of the next prime finder: search sequencer and result register.
//
// Usage: the input channel (req_valid, req_stall, req_start_value) takes one
// signed start value per transfer; the low DATA_WIDTH bits are read as a
// two's complement number. The result channel (rsp_valid, rsp_stall,
// rsp_next_prime) returns one transfer per input: the smallest prime not
// below max(start value, 2).
// A start value of 2 or less gives 2 without trial division. Otherwise each
// candidate is tried by trial division with divisors 2, 3, ... while the
// divisor squared does not exceed it; each divisor takes one pass over the
// 31 dividend bits on the shared bit-serial remainder unit, plus issue and
// check. A prime near 2^31 is tried with about 46340 divisors; composite
// candidates end at their smallest factor.
// Throughput: one item at a time; req_stall is high from transfer until the
// result is written into the output register.
// The next item is taken while a finished result still waits for the
// receiver. If a second result completes before the first is taken, the
// sequencer holds it until rsp_stall goes low.
// Reset clears the sequencer, the remainder unit and rsp_valid.
module next_prime_finder
   import npf_pkg::*;
#(
   parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [IN_WIDTH-1:0]  req_start_value,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [RES_WIDTH-1:0] rsp_next_prime
);

`include "next_prime_finder_defines.svh"

   state_type            state_ff, state_in;
   logic [RES_WIDTH-1:0] cand_ff, cand_in;
   logic [DIV_WIDTH-1:0] dvsr_ff, dvsr_in;
   logic [SQ_WIDTH-1:0]  sq_ff, sq_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RES_WIDTH-1:0] rsp_prime_ff, rsp_prime_in;

   logic [DATA_WIDTH-1:0] raw;
   logic                  trivial;
   logic                  req_xfer;
   logic                  rsp_xfer;
   logic                  div_start;
   logic                  div_busy;
   div_status_type        div_status;

   assign raw      = req_start_value[DATA_WIDTH-1:0];
   assign trivial  = raw[DATA_WIDTH-1] || (raw <= DATA_WIDTH'(2));
   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid_ff && !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      cand_in      = cand_ff;
      dvsr_in      = dvsr_ff;
      sq_in        = sq_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_xfer;
      rsp_prime_in = rsp_prime_ff;
      div_start    = 1'b0;
      req_stall    = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (trivial) begin
                  cand_in  = SMALLEST_PRIME;
                  state_in = ST_DONE;
               end else begin
                  cand_in  = RES_WIDTH'(raw);
                  state_in = ST_CAND;
               end
            end
         end
         ST_CAND: begin
            // The largest 31-bit value is prime: stop there untested.
            if (cand_ff == RESULT_MAX) begin
               state_in = ST_DONE;
            end else begin
               dvsr_in  = FIRST_DIVISOR;
               sq_in    = FIRST_SQUARE;
               state_in = ST_TEST;
            end
         end
         ST_TEST: begin
            if (sq_ff > {1'b0, cand_ff}) begin
               state_in = ST_DONE;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               if (div_status.rem_zero) begin
                  cand_in  = cand_ff + 1'b1;
                  state_in = ST_CAND;
               end else begin
                  // Advance the square incrementally: (d+1)^2 = d^2 + 2d + 1.
                  dvsr_in  = dvsr_ff + 1'b1;
                  sq_in    = sq_ff + SQ_WIDTH'({dvsr_ff, 1'b1});
                  state_in = ST_TEST;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_xfer) begin
               rsp_valid_in = 1'b1;
               rsp_prime_in = cand_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cand_ff      <= cand_in;
      dvsr_ff      <= dvsr_in;
      sq_ff        <= sq_in;
      rsp_prime_ff <= rsp_prime_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   npf_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (cand_ff),
      .divisor  (dvsr_ff),
      .busy     (div_busy),
      .status   (div_status)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_next_prime = rsp_prime_ff;

   `NPF_ASSERT_NEXT(a_req_leaves_idle, req_xfer, state_ff != ST_IDLE, "accepted item left idle state")
   `NPF_ASSERT_NEXT(a_div_runs, div_start, div_busy, "remainder unit did not start")
   `NPF_ASSERT_NOW(a_square_tracks, state_ff == ST_TEST,
      sq_ff == SQ_WIDTH'(dvsr_ff) * SQ_WIDTH'(dvsr_ff), "divisor square out of step")
   `NPF_ASSERT_NOW(a_div_idle_in_test, state_ff == ST_TEST, !div_busy && !div_status.done,
      "remainder unit busy at divisor test")

endmodule
